@@ rtl/glyph_text_framebuffer_render_top_defines.svh @@
// ----------------------------------------------------------------------------
// Glyph text framebuffer assertion macros
// Shared property forms for the assertions of the text renderer.
// ----------------------------------------------------------------------------
`ifndef GLYPH_TEXT_FRAMEBUFFER_RENDER_TOP_DEFINES_SVH
`define GLYPH_TEXT_FRAMEBUFFER_RENDER_TOP_DEFINES_SVH

// Same-cycle implication on the block clock.
`define GTFB_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gtfb assertion failed");

// Next-cycle implication on the block clock.
`define GTFB_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gtfb assertion failed");

`endif

@@ rtl/gtfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Glyph text framebuffer package
// Request and response types, request codes and the font table.
// ----------------------------------------------------------------------------
package gtfb_pkg;

   localparam logic [1:0] REQ_DRAW  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] char_code;
      logic [5:0] pixel_row;
      logic [6:0] column;
      logic [2:0] read_page;
      logic       invert;
      logic       starts_string;
   } gtfb_req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] next_column;
   } gtfb_rsp_type;

   typedef struct packed {
      logic [2:0]      width;
      logic [6:0][7:0] cols;
   } glyph_type;

   function automatic glyph_type glyph_make(input logic [2:0] w,
      input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
      input logic [7:0] d, input logic [7:0] e, input logic [7:0] f,
      input logic [7:0] h);
      glyph_type g;
      g.width   = w;
      g.cols[0] = a;
      g.cols[1] = b;
      g.cols[2] = c;
      g.cols[3] = d;
      g.cols[4] = e;
      g.cols[5] = f;
      g.cols[6] = h;
      return g;
   endfunction

   function automatic glyph_type font_lookup(input logic [7:0] code);
      glyph_type g;
      case (code)
         8'h18: g = glyph_make(3'd5, 8'h04, 8'h06, 8'h7F, 8'h06, 8'h04, 8'h00, 8'h00);
         8'h19: g = glyph_make(3'd5, 8'h10, 8'h30, 8'h7F, 8'h30, 8'h10, 8'h00, 8'h00);
         8'h1E: g = glyph_make(3'd7, 8'h10, 8'h30, 8'h70, 8'hF0, 8'h70, 8'h30, 8'h10);
         8'h1F: g = glyph_make(3'd7, 8'h08, 8'h0C, 8'h0E, 8'h0F, 8'h0E, 8'h0C, 8'h08);
         8'h20: g = glyph_make(3'd4, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h28: g = glyph_make(3'd2, 8'h3E, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h29: g = glyph_make(3'd2, 8'h41, 8'h3E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h2B: g = glyph_make(3'd5, 8'h08, 8'h08, 8'h3E, 8'h08, 8'h08, 8'h00, 8'h00);
         8'h2C: g = glyph_make(3'd2, 8'hE0, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h2D: g = glyph_make(3'd5, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00, 8'h00);
         8'h2E: g = glyph_make(3'd4, 8'h00, 8'h60, 8'h60, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h2F: g = glyph_make(3'd5, 8'h20, 8'h10, 8'h08, 8'h04, 8'h02, 8'h00, 8'h00);
         8'h30: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h00);
         8'h31: g = glyph_make(3'd3, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h32: g = glyph_make(3'd5, 8'h62, 8'h51, 8'h49, 8'h49, 8'h46, 8'h00, 8'h00);
         8'h33: g = glyph_make(3'd5, 8'h22, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00);
         8'h34: g = glyph_make(3'd5, 8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00, 8'h00);
         8'h35: g = glyph_make(3'd5, 8'h2F, 8'h49, 8'h49, 8'h49, 8'h31, 8'h00, 8'h00);
         8'h36: g = glyph_make(3'd5, 8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30, 8'h00, 8'h00);
         8'h37: g = glyph_make(3'd5, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03, 8'h00, 8'h00);
         8'h38: g = glyph_make(3'd5, 8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00);
         8'h39: g = glyph_make(3'd5, 8'h06, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00, 8'h00);
         8'h3A: g = glyph_make(3'd2, 8'h6C, 8'h6C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h3C: g = glyph_make(3'd4, 8'h08, 8'h14, 8'h22, 8'h41, 8'h00, 8'h00, 8'h00);
         8'h3D: g = glyph_make(3'd5, 8'h24, 8'h24, 8'h24, 8'h24, 8'h24, 8'h00, 8'h00);
         8'h3E: g = glyph_make(3'd4, 8'h41, 8'h22, 8'h14, 8'h08, 8'h00, 8'h00, 8'h00);
         8'h41: g = glyph_make(3'd5, 8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E, 8'h00, 8'h00);
         8'h42: g = glyph_make(3'd5, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00);
         8'h43: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 8'h00, 8'h00);
         8'h44: g = glyph_make(3'd5, 8'h7F, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h00);
         8'h45: g = glyph_make(3'd5, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00, 8'h00);
         8'h46: g = glyph_make(3'd5, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h01, 8'h00, 8'h00);
         8'h47: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A, 8'h00, 8'h00);
         8'h48: g = glyph_make(3'd5, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h00);
         8'h49: g = glyph_make(3'd3, 8'h41, 8'h7F, 8'h41, 8'h00, 8'h00, 8'h00, 8'h00);
         8'h4A: g = glyph_make(3'd5, 8'h30, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00, 8'h00);
         8'h4B: g = glyph_make(3'd5, 8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 8'h00, 8'h00);
         8'h4C: g = glyph_make(3'd5, 8'h7F, 8'h40, 8'h40, 8'h40, 8'h40, 8'h00, 8'h00);
         8'h4D: g = glyph_make(3'd5, 8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F, 8'h00, 8'h00);
         8'h4E: g = glyph_make(3'd5, 8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F, 8'h00, 8'h00);
         8'h4F: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h00);
         8'h50: g = glyph_make(3'd5, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00, 8'h00);
         8'h51: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E, 8'h00, 8'h00);
         8'h52: g = glyph_make(3'd5, 8'h7F, 8'h09, 8'h09, 8'h19, 8'h66, 8'h00, 8'h00);
         8'h53: g = glyph_make(3'd5, 8'h26, 8'h49, 8'h49, 8'h49, 8'h32, 8'h00, 8'h00);
         8'h54: g = glyph_make(3'd5, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00, 8'h00);
         8'h55: g = glyph_make(3'd5, 8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F, 8'h00, 8'h00);
         8'h56: g = glyph_make(3'd5, 8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F, 8'h00, 8'h00);
         8'h57: g = glyph_make(3'd5, 8'h3F, 8'h40, 8'h3C, 8'h40, 8'h3F, 8'h00, 8'h00);
         8'h58: g = glyph_make(3'd5, 8'h63, 8'h14, 8'h08, 8'h14, 8'h63, 8'h00, 8'h00);
         8'h59: g = glyph_make(3'd5, 8'h07, 8'h08, 8'h70, 8'h08, 8'h07, 8'h00, 8'h00);
         8'hC0: g = glyph_make(3'd5, 8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E, 8'h00, 8'h00);
         8'hC1: g = glyph_make(3'd5, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h31, 8'h00, 8'h00);
         8'hC2: g = glyph_make(3'd5, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00);
         8'hC3: g = glyph_make(3'd5, 8'h7F, 8'h01, 8'h01, 8'h01, 8'h01, 8'h00, 8'h00);
         8'hC4: g = glyph_make(3'd6, 8'hC0, 8'h7E, 8'h41, 8'h41, 8'h7F, 8'hC0, 8'h00);
         8'hC5: g = glyph_make(3'd5, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h41, 8'h00, 8'h00);
         8'hC6: g = glyph_make(3'd5, 8'h77, 8'h08, 8'h7F, 8'h08, 8'h77, 8'h00, 8'h00);
         8'hC7: g = glyph_make(3'd5, 8'h22, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00, 8'h00);
         8'hC8: g = glyph_make(3'd5, 8'h7F, 8'h20, 8'h10, 8'h08, 8'h7F, 8'h00, 8'h00);
         8'hC9: g = glyph_make(3'd5, 8'h7E, 8'h21, 8'h11, 8'h09, 8'h7E, 8'h00, 8'h00);
         8'hCA: g = glyph_make(3'd5, 8'h7F, 8'h08, 8'h14, 8'h22, 8'h41, 8'h00, 8'h00);
         8'hCB: g = glyph_make(3'd5, 8'h40, 8'h7E, 8'h01, 8'h01, 8'h7F, 8'h00, 8'h00);
         8'hCC: g = glyph_make(3'd5, 8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F, 8'h00, 8'h00);
         8'hCD: g = glyph_make(3'd5, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h00);
         8'hCE: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E, 8'h00, 8'h00);
         8'hCF: g = glyph_make(3'd5, 8'h7F, 8'h01, 8'h01, 8'h01, 8'h7F, 8'h00, 8'h00);
         8'hD0: g = glyph_make(3'd5, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06, 8'h00, 8'h00);
         8'hD1: g = glyph_make(3'd5, 8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 8'h00, 8'h00);
         8'hD2: g = glyph_make(3'd5, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01, 8'h00, 8'h00);
         8'hD3: g = glyph_make(3'd5, 8'h27, 8'h48, 8'h48, 8'h48, 8'h3F, 8'h00, 8'h00);
         8'hD4: g = glyph_make(3'd5, 8'h0E, 8'h11, 8'h7F, 8'h11, 8'h0E, 8'h00, 8'h00);
         8'hD6: g = glyph_make(3'd5, 8'h7F, 8'h40, 8'h40, 8'h7F, 8'hC0, 8'h00, 8'h00);
         8'hD7: g = glyph_make(3'd5, 8'h07, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00, 8'h00);
         8'hD8: g = glyph_make(3'd5, 8'h7F, 8'h40, 8'h7F, 8'h40, 8'h7F, 8'h00, 8'h00);
         8'hD9: g = glyph_make(3'd5, 8'h7F, 8'h40, 8'h7F, 8'h40, 8'hFF, 8'h00, 8'h00);
         8'hDB: g = glyph_make(3'd5, 8'h7F, 8'h48, 8'h48, 8'h30, 8'h7F, 8'h00, 8'h00);
         8'hDC: g = glyph_make(3'd5, 8'h7F, 8'h48, 8'h48, 8'h48, 8'h30, 8'h00, 8'h00);
         8'hDD: g = glyph_make(3'd5, 8'h22, 8'h41, 8'h49, 8'h49, 8'h3E, 8'h00, 8'h00);
         8'hDE: g = glyph_make(3'd5, 8'h7F, 8'h08, 8'h3E, 8'h41, 8'h3E, 8'h00, 8'h00);
         8'hDF: g = glyph_make(3'd5, 8'h66, 8'h19, 8'h09, 8'h09, 8'h7F, 8'h00, 8'h00);
         8'hF6: g = glyph_make(3'd5, 8'h7C, 8'h40, 8'h40, 8'h7C, 8'hC0, 8'h00, 8'h00);
         default: g = glyph_make(3'd5, 8'h2A, 8'h1C, 8'h36, 8'h1C, 8'h2A, 8'h00, 8'h00);
      endcase
      return g;
   endfunction

endpackage

@@ rtl/gtfb_fbmem.sv @@
// ----------------------------------------------------------------------------
// Glyph text framebuffer memory
// Single write port, single read port memory with registered read data.
// ----------------------------------------------------------------------------
module gtfb_fbmem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ rtl/glyph_text_framebuffer_render_top.sv @@
// ----------------------------------------------------------------------------
// Glyph text framebuffer renderer
// Draws font glyphs into a page-organized monochrome framebuffer.
// ----------------------------------------------------------------------------
// Requests arrive on req_valid/req_stall and carry a draw, read or clear.
// Every request returns exactly one response on rsp_valid/rsp_stall.
// A draw visits up to nine columns; each visible column costs a read and a
// write of the framebuffer byte in its page and of the byte in the page below,
// each byte read in ST_SEL and written back in ST_WR. A read waits in
// ST_RWAIT for the registered read data. A clear sweeps the memory one byte
// per cycle. After reset the block runs the same sweep before it takes its
// first request. A new request is taken as soon as the previous one has
// finished its work, even while its response still waits. A stalled response
// holds its value, and a finished request waits until the response register
// is free.
// ----------------------------------------------------------------------------
`include "glyph_text_framebuffer_render_top_defines.svh"

module glyph_text_framebuffer_render_top #(
   parameter int PAGES   = 8,
   parameter int COLUMNS = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gtfb_pkg::gtfb_req_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gtfb_pkg::gtfb_rsp_type rsp_payload
);

   import gtfb_pkg::*;

   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLR   = 3'd1;
   localparam logic [2:0] ST_SEL   = 3'd2;
   localparam logic [2:0] ST_WR    = 3'd3;
   localparam logic [2:0] ST_RWAIT = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]    state_ff, state_in;
   glyph_type     glyph_ff, glyph_in;
   logic [4:0]    page_ff, page_in;
   logic [2:0]    off_ff, off_in;
   logic          inv_ff, inv_in;
   logic          lead_ff, lead_in;
   logic [7:0]    col_ff, col_in;
   logic [3:0]    k_ff, k_in;
   logic [3:0]    n_ff, n_in;
   logic          half_ff, half_in;
   logic [7:0]    next_ff, next_in;
   logic [7:0]    rdata_ff, rdata_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic          clrrsp_ff, clrrsp_in;
   logic          rsp_valid_ff, rsp_valid_in;
   gtfb_rsp_type  rsp_ff, rsp_in;

   logic          accept;
   logic [8:0]    x;
   logic [4:0]    tpage;
   logic [3:0]    j;
   logic [8:0]    bits9;
   logic [15:0]   d16;
   logic [7:0]    byte_or;
   logic [AW-1:0] addr;
   logic          visible;
   logic [8:0]    end_x;
   logic [3:0]    n_new;
   glyph_type     glyph_new;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   gtfb_fbmem #(.DEPTH(DEPTH), .AW(AW)) u_fbmem (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign glyph_new = font_lookup(req_payload.char_code);
   assign n_new = 4'({3'd0, req_payload.starts_string}) + 4'({1'b0, glyph_new.width}) + 4'd1;

   always_comb begin
      x     = 9'(col_ff) + 9'(k_ff);
      tpage = page_ff + 5'(half_ff);
      j     = k_ff - 4'(lead_ff);
      if ((lead_ff && (k_ff == 4'd0)) || (j >= 4'({1'b0, glyph_ff.width}))) begin
         bits9 = 9'd0;
      end else begin
         bits9 = {glyph_ff.cols[j[2:0]], 1'b0};
      end
      d16     = 16'(bits9 ^ {9{inv_ff}}) << off_ff;
      byte_or = half_ff ? d16[15:8] : d16[7:0];
      visible = (int'(x) < COLUMNS) && (int'(tpage) < PAGES);
      addr    = AW'(int'(tpage) * COLUMNS + int'(x));
      end_x   = 9'(req_payload.column) + 9'(n_new);
   end

   always_comb begin
      state_in     = state_ff;
      glyph_in     = glyph_ff;
      page_in      = page_ff;
      off_in       = off_ff;
      inv_in       = inv_ff;
      lead_in      = lead_ff;
      col_in       = col_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      half_in      = half_ff;
      next_in      = next_ff;
      rdata_in     = rdata_ff;
      clr_in       = clr_ff;
      clrrsp_in    = clrrsp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = addr;
      wr_data      = rd_data | byte_or;
      rd_en        = 1'b0;
      rd_addr      = addr;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rdata_in = 8'd0;
               next_in  = 8'd0;
               unique case (req_payload.req_type)
                  REQ_DRAW: begin
                     glyph_in = glyph_new;
                     page_in  = 5'(req_payload.pixel_row[5:3]);
                     off_in   = req_payload.pixel_row[2:0];
                     inv_in   = req_payload.invert;
                     lead_in  = req_payload.starts_string;
                     col_in   = 8'(req_payload.column);
                     k_in     = 4'd0;
                     half_in  = 1'b0;
                     n_in     = n_new;
                     if (int'(req_payload.column) >= COLUMNS) begin
                        next_in = 8'(COLUMNS);
                     end else if (int'(end_x) > COLUMNS) begin
                        next_in = 8'(COLUMNS);
                     end else begin
                        next_in = end_x[7:0];
                     end
                     state_in = ST_SEL;
                  end
                  REQ_READ: begin
                     rd_addr = AW'(int'(req_payload.read_page) * COLUMNS
                                   + int'(req_payload.column));
                     if ((int'(req_payload.read_page) < PAGES)
                         && (int'(req_payload.column) < COLUMNS)) begin
                        rd_en    = 1'b1;
                        state_in = ST_RWAIT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  REQ_CLEAR: begin
                     clr_in    = '0;
                     clrrsp_in = 1'b1;
                     state_in  = ST_CLR;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CLR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = 8'd0;
            clr_in  = clr_ff + AW'(1);
            if (int'(clr_ff) == DEPTH - 1) begin
               state_in = clrrsp_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_SEL: begin
            if (k_ff == n_ff) begin
               state_in = ST_DONE;
            end else if (visible) begin
               rd_en    = 1'b1;
               state_in = ST_WR;
            end else begin
               half_in = !half_ff;
               if (half_ff) begin
                  k_in = k_ff + 4'd1;
               end
            end
         end
         ST_WR: begin
            wr_en    = 1'b1;
            half_in  = !half_ff;
            if (half_ff) begin
               k_in = k_ff + 4'd1;
            end
            state_in = ST_SEL;
         end
         ST_RWAIT: begin
            rdata_in = rd_data;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in       = 1'b1;
               rsp_in.read_data   = rdata_ff;
               rsp_in.next_column = next_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         clrrsp_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clrrsp_ff    <= clrrsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      glyph_ff <= glyph_in;
      page_ff  <= page_in;
      off_ff   <= off_in;
      inv_ff   <= inv_in;
      lead_ff  <= lead_in;
      col_ff   <= col_in;
      k_ff     <= k_in;
      n_ff     <= n_in;
      half_ff  <= half_in;
      next_ff  <= next_in;
      rdata_ff <= rdata_in;
      rsp_ff   <= rsp_in;
   end

   `GTFB_ASSERT_NOW(a_idle_no_write, state_ff == ST_IDLE, !wr_en)
   `GTFB_ASSERT_NEXT(a_draw_starts, accept && (req_payload.req_type == REQ_DRAW),
      state_ff == ST_SEL)
   `GTFB_ASSERT_NEXT(a_wr_after_read, (state_ff == ST_SEL) && rd_en, state_ff == ST_WR)
   `GTFB_ASSERT_NEXT(a_rsp_from_done, !rsp_valid_ff && (state_ff != ST_DONE), !rsp_valid_ff)

endmodule

@@ verif/glyph_text_framebuffer_render_top_tb.sv @@
// ----------------------------------------------------------------------------
// Glyph text framebuffer renderer testbench
// Drives draw, read and clear requests with random gaps and response stalls,
// keeps its own framebuffer image, and checks every response field against
// the value that image predicts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module glyph_text_framebuffer_render_top_tb;
   import gtfb_pkg::*;

   localparam int PAGES   = 8;
   localparam int COLUMNS = 128;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   gtfb_req_type req_payload = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   gtfb_rsp_type rsp_payload;

   int  mismatch_count = 0;
   bit  stall_hold = 1'b0;

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatch_count++;
   endtask

   // Independent font table; the unlisted codes fall to the star-like glyph.
   function automatic glyph_type font_glyph(input logic [7:0] code);
      glyph_type g;
      logic [7:0] c [7];
      int w;
      w = 5;
      c = '{8'h2A, 8'h1C, 8'h36, 8'h1C, 8'h2A, 8'h00, 8'h00};
      case (code)
         8'h18: c = '{8'h04,8'h06,8'h7F,8'h06,8'h04,0,0};
         8'h19: c = '{8'h10,8'h30,8'h7F,8'h30,8'h10,0,0};
         8'h1E: begin w = 7; c = '{8'h10,8'h30,8'h70,8'hF0,8'h70,8'h30,8'h10}; end
         8'h1F: begin w = 7; c = '{8'h08,8'h0C,8'h0E,8'h0F,8'h0E,8'h0C,8'h08}; end
         8'h20: begin w = 4; c = '{0,0,0,0,0,0,0}; end
         8'h28: begin w = 2; c = '{8'h3E,8'h41,0,0,0,0,0}; end
         8'h29: begin w = 2; c = '{8'h41,8'h3E,0,0,0,0,0}; end
         8'h2B: c = '{8'h08,8'h08,8'h3E,8'h08,8'h08,0,0};
         8'h2C: begin w = 2; c = '{8'hE0,8'h60,0,0,0,0,0}; end
         8'h2D: c = '{8'h08,8'h08,8'h08,8'h08,8'h08,0,0};
         8'h2E: begin w = 4; c = '{8'h00,8'h60,8'h60,8'h00,0,0,0}; end
         8'h2F: c = '{8'h20,8'h10,8'h08,8'h04,8'h02,0,0};
         8'h30: c = '{8'h3E,8'h41,8'h41,8'h41,8'h3E,0,0};
         8'h31: begin w = 3; c = '{8'h42,8'h7F,8'h40,0,0,0,0}; end
         8'h32: c = '{8'h62,8'h51,8'h49,8'h49,8'h46,0,0};
         8'h33: c = '{8'h22,8'h49,8'h49,8'h49,8'h36,0,0};
         8'h34: c = '{8'h18,8'h14,8'h12,8'h7F,8'h10,0,0};
         8'h35: c = '{8'h2F,8'h49,8'h49,8'h49,8'h31,0,0};
         8'h36: c = '{8'h3C,8'h4A,8'h49,8'h49,8'h30,0,0};
         8'h37: c = '{8'h01,8'h71,8'h09,8'h05,8'h03,0,0};
         8'h38: c = '{8'h36,8'h49,8'h49,8'h49,8'h36,0,0};
         8'h39: c = '{8'h06,8'h49,8'h49,8'h29,8'h1E,0,0};
         8'h3A: begin w = 2; c = '{8'h6C,8'h6C,0,0,0,0,0}; end
         8'h3C: begin w = 4; c = '{8'h08,8'h14,8'h22,8'h41,0,0,0}; end
         8'h3D: c = '{8'h24,8'h24,8'h24,8'h24,8'h24,0,0};
         8'h3E: begin w = 4; c = '{8'h41,8'h22,8'h14,8'h08,0,0,0}; end
         8'h41: c = '{8'h7E,8'h11,8'h11,8'h11,8'h7E,0,0};
         8'h42: c = '{8'h7F,8'h49,8'h49,8'h49,8'h36,0,0};
         8'h43: c = '{8'h3E,8'h41,8'h41,8'h41,8'h22,0,0};
         8'h44: c = '{8'h7F,8'h41,8'h41,8'h41,8'h3E,0,0};
         8'h45: c = '{8'h7F,8'h49,8'h49,8'h49,8'h41,0,0};
         8'h46: c = '{8'h7F,8'h09,8'h09,8'h09,8'h01,0,0};
         8'h47: c = '{8'h3E,8'h41,8'h49,8'h49,8'h7A,0,0};
         8'h48: c = '{8'h7F,8'h08,8'h08,8'h08,8'h7F,0,0};
         8'h49: begin w = 3; c = '{8'h41,8'h7F,8'h41,0,0,0,0}; end
         8'h4A: c = '{8'h30,8'h40,8'h40,8'h40,8'h3F,0,0};
         8'h4B: c = '{8'h7F,8'h08,8'h14,8'h22,8'h41,0,0};
         8'h4C: c = '{8'h7F,8'h40,8'h40,8'h40,8'h40,0,0};
         8'h4D: c = '{8'h7F,8'h02,8'h04,8'h02,8'h7F,0,0};
         8'h4E: c = '{8'h7F,8'h02,8'h04,8'h08,8'h7F,0,0};
         8'h4F: c = '{8'h3E,8'h41,8'h41,8'h41,8'h3E,0,0};
         8'h50: c = '{8'h7F,8'h09,8'h09,8'h09,8'h06,0,0};
         8'h51: c = '{8'h3E,8'h41,8'h51,8'h21,8'h5E,0,0};
         8'h52: c = '{8'h7F,8'h09,8'h09,8'h19,8'h66,0,0};
         8'h53: c = '{8'h26,8'h49,8'h49,8'h49,8'h32,0,0};
         8'h54: c = '{8'h01,8'h01,8'h7F,8'h01,8'h01,0,0};
         8'h55: c = '{8'h3F,8'h40,8'h40,8'h40,8'h3F,0,0};
         8'h56: c = '{8'h1F,8'h20,8'h40,8'h20,8'h1F,0,0};
         8'h57: c = '{8'h3F,8'h40,8'h3C,8'h40,8'h3F,0,0};
         8'h58: c = '{8'h63,8'h14,8'h08,8'h14,8'h63,0,0};
         8'h59: c = '{8'h07,8'h08,8'h70,8'h08,8'h07,0,0};
         8'hC0: c = '{8'h7E,8'h11,8'h11,8'h11,8'h7E,0,0};
         8'hC1: c = '{8'h7F,8'h49,8'h49,8'h49,8'h31,0,0};
         8'hC2: c = '{8'h7F,8'h49,8'h49,8'h49,8'h36,0,0};
         8'hC3: c = '{8'h7F,8'h01,8'h01,8'h01,8'h01,0,0};
         8'hC4: begin w = 6; c = '{8'hC0,8'h7E,8'h41,8'h41,8'h7F,8'hC0,0}; end
         8'hC5: c = '{8'h7F,8'h49,8'h49,8'h49,8'h41,0,0};
         8'hC6: c = '{8'h77,8'h08,8'h7F,8'h08,8'h77,0,0};
         8'hC7: c = '{8'h22,8'h49,8'h49,8'h49,8'h36,0,0};
         8'hC8: c = '{8'h7F,8'h20,8'h10,8'h08,8'h7F,0,0};
         8'hC9: c = '{8'h7E,8'h21,8'h11,8'h09,8'h7E,0,0};
         8'hCA: c = '{8'h7F,8'h08,8'h14,8'h22,8'h41,0,0};
         8'hCB: c = '{8'h40,8'h7E,8'h01,8'h01,8'h7F,0,0};
         8'hCC: c = '{8'h7F,8'h02,8'h04,8'h02,8'h7F,0,0};
         8'hCD: c = '{8'h7F,8'h08,8'h08,8'h08,8'h7F,0,0};
         8'hCE: c = '{8'h3E,8'h41,8'h41,8'h41,8'h3E,0,0};
         8'hCF: c = '{8'h7F,8'h01,8'h01,8'h01,8'h7F,0,0};
         8'hD0: c = '{8'h7F,8'h09,8'h09,8'h09,8'h06,0,0};
         8'hD1: c = '{8'h3E,8'h41,8'h41,8'h41,8'h22,0,0};
         8'hD2: c = '{8'h01,8'h01,8'h7F,8'h01,8'h01,0,0};
         8'hD3: c = '{8'h27,8'h48,8'h48,8'h48,8'h3F,0,0};
         8'hD4: c = '{8'h0E,8'h11,8'h7F,8'h11,8'h0E,0,0};
         8'hD6: c = '{8'h7F,8'h40,8'h40,8'h7F,8'hC0,0,0};
         8'hD7: c = '{8'h07,8'h08,8'h08,8'h08,8'h7F,0,0};
         8'hD8: c = '{8'h7F,8'h40,8'h7F,8'h40,8'h7F,0,0};
         8'hD9: c = '{8'h7F,8'h40,8'h7F,8'h40,8'hFF,0,0};
         8'hDB: c = '{8'h7F,8'h48,8'h48,8'h30,8'h7F,0,0};
         8'hDC: c = '{8'h7F,8'h48,8'h48,8'h48,8'h30,0,0};
         8'hDD: c = '{8'h22,8'h41,8'h49,8'h49,8'h3E,0,0};
         8'hDE: c = '{8'h7F,8'h08,8'h3E,8'h41,8'h3E,0,0};
         8'hDF: c = '{8'h66,8'h19,8'h09,8'h09,8'h7F,0,0};
         8'hF6: c = '{8'h7C,8'h40,8'h40,8'h7C,8'hC0,0,0};
         default: ;
      endcase
      g.width = w[2:0];
      for (int i = 0; i < 7; i++) g.cols[i] = c[i];
      return g;
   endfunction

   class render_scoreboard;
      logic [7:0]   pixels [PAGES*COLUMNS];
      gtfb_rsp_type pending_rsp [$];

      function new();
         foreach (pixels[i]) pixels[i] = 8'h00;
      endfunction

      function void or_column(input logic [8:0] bits, input int page, input int offs,
                              input bit inv, input int x);
         logic [15:0] d;
         if (x >= COLUMNS) return;
         d = {7'd0, inv ? (bits ^ 9'h1FF) : bits} << offs;
         if (page < PAGES) pixels[page*COLUMNS + x] |= d[7:0];
         if (page + 1 < PAGES) pixels[(page+1)*COLUMNS + x] |= d[15:8];
      endfunction

      function void note_request(input gtfb_req_type r);
         gtfb_rsp_type e;
         glyph_type    g;
         int page, offs, x;
         e = '0;
         if (r.req_type == REQ_DRAW) begin
            page = r.pixel_row >> 3;
            offs = r.pixel_row & 7;
            x = r.column;
            g = font_glyph(r.char_code);
            if (r.starts_string) begin
               or_column(9'd0, page, offs, r.invert, x);
               x++;
            end
            for (int c = 0; c < g.width; c++) begin
               or_column({g.cols[c], 1'b0}, page, offs, r.invert, x);
               x++;
            end
            or_column(9'd0, page, offs, r.invert, x);
            x++;
            if (x > COLUMNS) x = COLUMNS;
            e.next_column = x[7:0];
         end else if (r.req_type == REQ_READ) begin
            e.read_data = pixels[r.read_page*COLUMNS + r.column];
         end else if (r.req_type == REQ_CLEAR) begin
            foreach (pixels[i]) pixels[i] = 8'h00;
         end
         pending_rsp.push_back(e);
      endfunction

      task check_response(input gtfb_rsp_type got);
         gtfb_rsp_type want;
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected response", got, 0);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
         if (got.next_column !== want.next_column)
            report_mismatch("next_column", got.next_column, want.next_column);
      endtask
   endclass

   render_scoreboard board = new();

   glyph_text_framebuffer_render_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int gap_length();
      int p;
      p = $urandom_range(99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(3, 1);
      return $urandom_range(40, 4);
   endfunction

   task automatic send_request(input gtfb_req_type r);
      int gap;
      gap = gap_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_rsp.size() != 0) @(posedge clock);
   endtask

   function automatic gtfb_req_type make_draw(input logic [7:0] code, input logic [5:0] row,
      input logic [6:0] col, input bit inv, input bit lead);
      gtfb_req_type r;
      r = gtfb_req_type'($urandom());
      r.req_type = REQ_DRAW;
      r.char_code = code;
      r.pixel_row = row;
      r.column = col;
      r.invert = inv;
      r.starts_string = lead;
      return r;
   endfunction

   function automatic gtfb_req_type make_read(input logic [2:0] page, input logic [6:0] col);
      gtfb_req_type r;
      r = gtfb_req_type'($urandom());
      r.req_type = REQ_READ;
      r.read_page = page;
      r.column = col;
      return r;
   endfunction

   function automatic gtfb_req_type random_request();
      gtfb_req_type r;
      int p;
      p = $urandom_range(99);
      r = gtfb_req_type'($urandom());
      if (p < 55) r.req_type = REQ_DRAW;
      else if (p < 95) r.req_type = REQ_READ;
      else if (p < 97) r.req_type = REQ_CLEAR;
      else r.req_type = 2'd3;
      return r;
   endfunction

   // Response side: random stalls, with one long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_payload);
   end

   initial begin
      int p;
      int run;
      run = 0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (stall_hold) begin
            rsp_stall <= 1'b1;
         end else if (run > 0) begin
            rsp_stall <= 1'b1;
            run--;
         end else begin
            p = $urandom_range(99);
            if (p < 25) run = $urandom_range(2, 0);
            else if (p < 27) run = $urandom_range(40, 4);
            rsp_stall <= (p < 27);
         end
      end
   end

   initial begin
      gtfb_req_type r;
      int drop_run;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every request type, edge and page spill cases.
      send_request(make_draw(8'h41, 6'd0, 7'd0, 1'b0, 1'b1));
      send_request(make_read(3'd0, 7'd1));
      send_request(make_draw(8'h1E, 6'd63, 7'd120, 1'b1, 1'b0));
      send_request(make_read(3'd7, 7'd127));
      send_request(make_draw(8'hFF, 6'd60, 7'd127, 1'b0, 1'b1));
      send_request(make_draw(8'h00, 6'd13, 7'd50, 1'b1, 1'b1));
      send_request(make_read(3'd1, 7'd52));
      send_request(make_read(3'd2, 7'd52));
      send_request(make_draw(8'hC4, 6'd7, 7'd124, 1'b0, 1'b0));
      send_request(make_draw(8'h28, 6'd56, 7'd64, 1'b1, 1'b0));
      send_request(make_read(3'd7, 7'd65));
      r = random_request();
      r.req_type = 2'd3;
      send_request(r);
      r.req_type = REQ_CLEAR;
      send_request(r);
      send_request(make_read(3'd0, 7'd1));
      send_request(make_read(3'd7, 7'd127));
      wait_drained();

      // Hold the response side off so the block fills and stalls its input.
      stall_hold = 1'b1;
      fork
         begin
            repeat (300) @(posedge clock);
            stall_hold = 1'b0;
         end
         for (int i = 0; i < 8; i++) send_request(random_request());
      join
      wait_drained();

      for (int n = 0; n < 1200; n++) begin
         if (n % 40 == 0) begin
            // Strings of glyphs followed by reads of what they touched.
            drop_run = $urandom_range(6, 2);
            r = make_draw(8'($urandom()), 6'($urandom()), 7'($urandom_range(127)),
                          $urandom_range(1), 1'b1);
            for (int k = 0; k < drop_run; k++) begin
               send_request(r);
               r.starts_string = 1'b0;
               r.char_code = 8'($urandom());
               r.column = r.column + 7'd8;
            end
            for (int k = 0; k < 4; k++)
               send_request(make_read(r.pixel_row[5:3] + 3'(k & 1),
                                      r.column - 7'($urandom_range(30))));
         end else begin
            send_request(random_request());
         end
         if (n == 600) wait_drained();
      end
      wait_drained();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && board.pending_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/gtfb_pkg.sv
rtl/gtfb_fbmem.sv
rtl/glyph_text_framebuffer_render_top.sv
verif/glyph_text_framebuffer_render_top_tb.sv
